FILE: src/pic_pkg.sv
// Package for the palette index compaction block.
// Holds the item types, the kind codes and the sizing constants of the used map.
// No dependencies.
package pic_pkg;

  localparam int PaletteEntries = 256;
  localparam int MapBits        = (PaletteEntries < 256) ? PaletteEntries : 256;
  localparam int GroupBits      = 16;
  localparam int NumGroups      = (MapBits + GroupBits - 1) / GroupBits;
  localparam int PadBits        = NumGroups * GroupBits;
  localparam int GroupIdxW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
  localparam int BitIdxW        = $clog2(PadBits);
  localparam int PopW           = $clog2(GroupBits + 1);
  localparam int CountW         = 9;

  typedef enum logic [1:0] {
    KindClear = 2'd0,
    KindMark  = 2'd1,
    KindRemap = 2'd2,
    KindQuery = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        new_index;
    logic              index_used;
    logic [CountW-1:0] color_count;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] pixel;
  } upd_t;

endpackage

FILE: src/palette_index_compaction.sv
// Top level of the palette index compaction block: input register, used map, result register.
// Depends on pic_pkg and pic_used_map.
//
//   Channel | Valid      | Stall       | Payload
//   --------+------------+-------------+-----------------------
//   input   | in_valid_i | in_stall_o  | in_data_i  (in_item_t)
//   output  | out_valid_o| out_stall_i | out_data_o (out_item_t)
//
// Every item gives one result after its transfer: it passes the input register and then
// the result register. One item is taken per cycle while the output is not stalled; this
// rests on the used map and its group prefix counts being updated as the item moves on.
// Reset clears the used map, the counts and both valid flags at once.
// A stall on a full result register holds it, and in the same cycle holds a full input register.
module palette_index_compaction import pic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  logic      s1_load;
  upd_t      upd;
  out_item_t res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || advance;
  assign in_stall_o = !s1_load;

  assign upd.valid = s1_valid_q && advance;
  assign upd.kind  = s1_item_q.kind;
  assign upd.pixel = s1_item_q.pixel_value;

  pic_used_map u_used_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
    if (advance && s1_valid_q) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

FILE: src/pic_used_map.sv
// Used map of the palette index compaction block, with per-group prefix counts.
// Computes the result of the pending item and applies its update to the map.
// Depends on pic_pkg.
module pic_used_map import pic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  upd_t      upd_i,
  output out_item_t res_o
);

  logic [PadBits-1:0]   map_q, map_d;
  logic [CountW-1:0]    prefix_q [NumGroups];
  logic [CountW-1:0]    prefix_d [NumGroups];
  logic [CountW-1:0]    count_q, count_d;

  logic                 in_palette;
  logic [GroupIdxW-1:0] grp;
  logic [3:0]           off;
  logic [BitIdxW-1:0]   bit_idx;
  logic [GroupBits-1:0] grp_bits;
  logic [GroupBits-1:0] below_bits;
  logic [PopW-1:0]      below_cnt;
  logic                 set_new;
  logic                 is_clear;

  always_comb begin
    in_palette = ({1'b0, upd_i.pixel} < CountW'(MapBits));
    grp        = in_palette ? GroupIdxW'(upd_i.pixel[7:4]) : '0;
    off        = upd_i.pixel[3:0];
    bit_idx    = in_palette ? BitIdxW'(upd_i.pixel) : '0;
    grp_bits   = map_q[grp*GroupBits +: GroupBits];
    below_bits = grp_bits & ((GroupBits'(1) << off) - GroupBits'(1));
    below_cnt  = '0;
    for (int i = 0; i < GroupBits; i++) begin
      below_cnt = below_cnt + PopW'(below_bits[i]);
    end
    is_clear = (upd_i.kind == KindClear);
    set_new  = upd_i.valid && (upd_i.kind == KindMark) && in_palette && !map_q[bit_idx];
  end

  always_comb begin
    map_d    = map_q;
    prefix_d = prefix_q;
    count_d  = count_q;
    if (upd_i.valid && is_clear) begin
      map_d   = '0;
      count_d = '0;
      for (int g = 0; g < NumGroups; g++) begin
        prefix_d[g] = '0;
      end
    end else if (set_new) begin
      map_d[bit_idx] = 1'b1;
      count_d        = count_q + CountW'(1);
      for (int g = 0; g < NumGroups; g++) begin
        if (GroupIdxW'(g) > grp) begin
          prefix_d[g] = prefix_q[g] + CountW'(1);
        end
      end
    end
  end

  always_comb begin
    if (is_clear) begin
      res_o = '0;
    end else begin
      res_o.new_index   = in_palette ? 8'(prefix_q[grp] + CountW'(below_cnt))
                                     : 8'(count_d);
      res_o.index_used  = in_palette && (map_q[bit_idx] || set_new);
      res_o.color_count = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      count_q <= '0;
      for (int g = 0; g < NumGroups; g++) begin
        prefix_q[g] <= '0;
      end
    end else begin
      map_q    <= map_d;
      count_q  <= count_d;
      prefix_q <= prefix_d;
    end
  end

  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CountW'($countones(map_q)))
    else $error("distinct count disagrees with the used map");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i.valid && is_clear) |=> (count_q == '0) && (map_q == '0))
    else $error("clear did not empty the used map");

  a_mark_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i.valid && upd_i.kind == KindMark && in_palette) |=> map_q[$past(bit_idx)])
    else $error("mark did not set the used bit");

  a_first_prefix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_q[0] == '0)
    else $error("prefix count of the first group is not zero");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for palette_index_compaction: directed and random mark and remap runs.
// A scoreboard class keeps its own copy of the used map and checks every result in order.
// Depends on pic_pkg and the palette_index_compaction RTL.
module testbench;
  import pic_pkg::*;

  localparam int IdleLimit = 1000;
  localparam int PixelTarget = 2000;

  class remap_scoreboard;
    logic [255:0] marked;
    logic [CountW-1:0] colors;
    out_item_t expected_remaps[$];
    int errors;
    int results_seen;

    function new();
      marked = '0;
      colors = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void note_pixel(in_item_t it);
      out_item_t r;
      int unsigned below;
      logic in_palette;
      r = '0;
      below = 0;
      in_palette = int'(it.pixel_value) < PaletteEntries;
      if (it.kind == KindClear) begin
        marked = '0;
        colors = '0;
      end else begin
        if (it.kind == KindMark && in_palette && !marked[it.pixel_value]) begin
          marked[it.pixel_value] = 1'b1;
          colors = colors + 1'b1;
        end
        for (int i = 0; i < int'(it.pixel_value); i++) begin
          below += marked[i];
        end
        r.new_index = below[7:0];
        r.index_used = in_palette && marked[it.pixel_value];
        r.color_count = colors;
      end
      expected_remaps.push_back(r);
    endfunction

    function void check_remap(out_item_t got);
      out_item_t exp;
      results_seen++;
      if (expected_remaps.size() == 0) begin
        $error("unexpected result: new_index %0d, index_used %0d, color_count %0d",
               got.new_index, got.index_used, got.color_count);
        errors++;
        return;
      end
      exp = expected_remaps.pop_front();
      if (got.new_index !== exp.new_index) begin
        $error("new_index: expected %0d, got %0d", exp.new_index, got.new_index);
        errors++;
      end
      if (got.index_used !== exp.index_used) begin
        $error("index_used: expected %0d, got %0d", exp.index_used, got.index_used);
        errors++;
      end
      if (got.color_count !== exp.color_count) begin
        $error("color_count: expected %0d, got %0d", exp.color_count, got.color_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_remaps.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  remap_scoreboard sb = new();
  int pixels_sent = 0;
  int hold_left = 0;
  bit held_off = 1'b0;
  int idle_cycles = 0;

  palette_index_compaction u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic offer(kind_e k, logic [7:0] px);
    in_item_t it;
    it.kind = k;
    it.pixel_value = px;
    while (!(pixels_sent >= 800 && pixels_sent < 1100) && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(it);
    pixels_sent++;
  endtask

  // Results are sampled before the stall for the next cycle is chosen.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_remap(out_data_o);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!held_off && sb.results_seen >= 400) begin
      held_off = 1'b1;
      hold_left = 80;
      out_stall_i <= 1'b1;
    end else if (sb.results_seen >= 800 && sb.results_seen < 1100) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("** palette_index_compaction: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] order[256];
    logic [7:0] shades[$];
    logic [7:0] tmp;
    int j;
    int n_colors;
    int n_items;
    int seq;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer(KindClear, 8'd0);
    offer(KindRemap, 8'd0);
    offer(KindRemap, 8'd255);
    offer(KindQuery, 8'd7);
    offer(KindMark, 8'd0);
    offer(KindMark, 8'd0);
    offer(KindMark, 8'd255);
    offer(KindMark, 8'd128);
    offer(KindRemap, 8'd0);
    offer(KindRemap, 8'd255);
    offer(KindRemap, 8'd128);
    offer(KindRemap, 8'd127);
    offer(KindQuery, 8'd200);
    offer(KindMark, 8'd1);
    offer(KindRemap, 8'd255);
    offer(KindMark, 8'd254);
    offer(KindQuery, 8'd255);
    offer(KindClear, 8'd255);
    offer(KindRemap, 8'd255);
    offer(KindMark, 8'd170);
    offer(KindMark, 8'd85);
    offer(KindRemap, 8'd170);
    offer(KindQuery, 8'd85);

    seq = 0;
    while (pixels_sent < PixelTarget) begin
      if (seq == 0 || $urandom_range(0, 11) == 0) begin
        // Fill the whole palette in shuffled order, then remap.
        for (int i = 0; i < 256; i++) order[i] = i[7:0];
        for (int i = 255; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        offer(KindClear, 8'($urandom()));
        for (int i = 0; i < 256; i++) offer(KindMark, order[i]);
        offer(KindRemap, 8'd255);
        offer(KindRemap, 8'd0);
        for (int i = 0; i < 30; i++) offer(KindRemap, 8'($urandom()));
      end else if ($urandom_range(0, 99) < 75) begin
        shades.delete();
        n_colors = $urandom_range(1, 24);
        for (int i = 0; i < n_colors; i++) shades.push_back(8'($urandom()));
        offer(KindClear, 8'($urandom()));
        n_items = $urandom_range(4, 60);
        for (int i = 0; i < n_items; i++) begin
          offer(KindMark, shades[$urandom_range(0, n_colors - 1)]);
        end
        n_items = $urandom_range(4, 60);
        for (int i = 0; i < n_items; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            offer(KindRemap, 8'($urandom()));
          end else if ($urandom_range(0, 9) == 0) begin
            offer(KindQuery, shades[$urandom_range(0, n_colors - 1)]);
          end else begin
            offer(KindRemap, shades[$urandom_range(0, n_colors - 1)]);
          end
        end
      end else begin
        n_items = $urandom_range(1, 10);
        for (int i = 0; i < n_items; i++) begin
          offer(kind_e'($urandom_range(0, 3)), 8'($urandom()));
        end
      end
      seq++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** palette_index_compaction: PASSED **");
    end else begin
      $display("** palette_index_compaction: FAILED **");
    end
    $finish;
  end

endmodule
